// File: hw/rtl/assert_macros.svh
// assertion macros used by the filter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define AWF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AWF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AWF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define AWF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: hw/rtl/awf_pkg.sv
// types and constants of the adaptive wiener image filter
package awf_pkg;

    localparam int MAX_WIDTH       = 512;
    localparam int MAX_HEIGHT      = 512;
    localparam int MAX_HALF_WINDOW = 7;

    localparam int PIX_W   = 16;
    localparam int DIM_W   = 10;
    localparam int HALF_W  = 3;
    localparam int OFS_W   = HALF_W + 1;
    localparam int SPAN_W  = HALF_W + 1;
    localparam int CNT_W   = 2 * SPAN_W;
    localparam int SUM_W   = PIX_W + CNT_W;
    localparam int SQ_W    = 2 * PIX_W + CNT_W;
    localparam int V_W     = SQ_W + CNT_W;
    localparam int TOT_W   = 64;
    localparam int NOISE_W = 40;
    localparam int COORD_W = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int NPIX_W  = ADDR_W + 1;
    localparam int ARITH_W = 96;
    localparam int STEP_W  = $clog2(ARITH_W + 1);
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // register indexes
    localparam logic [2:0] REG_DEPTH  = 3'd0;
    localparam logic [2:0] REG_HALF_W = 3'd1;
    localparam logic [2:0] REG_HALF_H = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    // transaction modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic {OP_MUL, OP_DIV} awf_op_t;

    typedef struct packed {
        logic                mode;
        logic [PIX_W-1:0]    pixel;
    } awf_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]    filtered_pixel;
        logic                last;
        logic [NOISE_W-1:0]  noise_variance;
        logic                status;
    } awf_out_t;

    typedef struct packed {
        logic                start;
        awf_op_t             op;
        logic [ARITH_W-1:0]  a;
        logic [ARITH_W-1:0]  b;
    } arith_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [ARITH_W-1:0]  quo;
        logic [ARITH_W:0]    rem;
    } arith_rsp_t;

endpackage

// File: hw/rtl/awf_arith.sv
// shared shift-add multiplier and restoring divider, one step per cycle
module awf_arith (
    input  logic                 clk,
    input  logic                 rst_n,
    input  awf_pkg::arith_req_t  req,
    output awf_pkg::arith_rsp_t  rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    awf_pkg::awf_op_t              op_reg;
    logic [awf_pkg::ARITH_W-1:0]   a_reg;
    logic [awf_pkg::ARITH_W-1:0]   b_reg;
    logic [awf_pkg::ARITH_W:0]     acc_reg;
    logic [awf_pkg::ARITH_W-1:0]   q_reg;
    logic [awf_pkg::STEP_W-1:0]    step_reg;

    logic [awf_pkg::ARITH_W:0]     trial;
    logic [awf_pkg::ARITH_W:0]     diff;
    logic                          fits;
    logic [awf_pkg::ARITH_W:0]     sum;

    // divide step: shift in next numerator bit and trial subtract
    assign trial = {acc_reg[awf_pkg::ARITH_W-1:0], a_reg[awf_pkg::ARITH_W-1]};
    assign fits  = trial >= {1'b0, b_reg};
    assign diff  = trial - {1'b0, b_reg};
    // multiply step: add shifted multiplicand when multiplier bit is set
    assign sum   = acc_reg + (b_reg[0] ? {1'b0, a_reg} : '0);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (op_reg == awf_pkg::OP_MUL)
                begin
                    if (b_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else if (step_reg == awf_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg   <= req.op;
            a_reg    <= req.a;
            b_reg    <= req.b;
            acc_reg  <= '0;
            q_reg    <= '0;
            step_reg <= awf_pkg::STEP_W'(awf_pkg::ARITH_W);
        end
        else if (busy_reg)
        begin
            if (op_reg == awf_pkg::OP_MUL)
            begin
                if (b_reg != '0)
                begin
                    acc_reg <= sum;
                    a_reg   <= a_reg << 1;
                    b_reg   <= b_reg >> 1;
                end
            end
            else
            begin
                acc_reg  <= fits ? diff : trial;
                q_reg    <= {q_reg[awf_pkg::ARITH_W-2:0], fits};
                a_reg    <= a_reg << 1;
                step_reg <= step_reg - awf_pkg::STEP_W'(1);
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = (op_reg == awf_pkg::OP_MUL) ? acc_reg[awf_pkg::ARITH_W-1:0] : q_reg;
    assign rsp.rem  = acc_reg;

endmodule

// File: hw/rtl/adaptive_wiener_image_filter_unit.sv
// adaptive wiener image filter: frame store, window sequencer and shared arithmetic
// a load leaves the unit idle, so the next load need not wait; the last load of a frame
// starts a pass that reads every pixel's window from the frame store, one read per window pixel
// a fetch reads the window, then runs shift-add steps and a divide in the shared unit;
// a fetch before the frame is complete answers in the next cycle. the result strobe lasts
// one cycle. reset clears positions, flags, the variance total and the registers to their
// defaults; the frame store is not cleared
`include "assert_macros.svh"
module adaptive_wiener_image_filter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  awf_pkg::awf_in_t            item,
    output logic                        done,
    output awf_pkg::awf_out_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [awf_pkg::APB_AW-1:0]  paddr,
    input  logic [awf_pkg::APB_DW-1:0]  pwdata,
    output logic [awf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_WIN, S_DRAIN, S_MUL_QC, S_MUL_SS, S_MUL_D, S_DIV_N,
        S_MUL_A, S_MUL_T1, S_MUL_NP, S_MUL_T2, S_MUL_DEN, S_DIV_F
    } state_t;

    // configuration
    logic                          depth_reg;
    logic [awf_pkg::HALF_W-1:0]    half_w_reg;
    logic [awf_pkg::HALF_W-1:0]    half_h_reg;
    logic [awf_pkg::DIM_W-1:0]     width_reg;
    logic [awf_pkg::DIM_W-1:0]     height_reg;

    // sequencer and frame state
    state_t                        state_reg;
    logic                          frame_ready_reg;
    logic                          pass_reg;
    logic [awf_pkg::NPIX_W-1:0]    load_pos_reg;
    logic [awf_pkg::NPIX_W-1:0]    rd_pos_reg;
    logic [awf_pkg::COORD_W-1:0]   rd_x_reg;
    logic [awf_pkg::ROW_W-1:0]     rd_y_reg;
    logic [awf_pkg::TOT_W-1:0]     total_reg;
    logic [awf_pkg::NOISE_W-1:0]   noise_reg;
    logic [awf_pkg::COORD_W-1:0]   cur_x_reg;
    logic [awf_pkg::ROW_W-1:0]     cur_y_reg;
    logic signed [awf_pkg::OFS_W-1:0] wx_reg;
    logic signed [awf_pkg::OFS_W-1:0] wy_reg;
    logic                          done_reg;
    awf_pkg::awf_out_t             result_reg;
    awf_pkg::arith_req_t           req_reg;

    // window pipeline
    logic                          v1_reg;
    logic                          c1_reg;
    logic                          v2_reg;
    logic [awf_pkg::PIX_W-1:0]     mem_q_reg;
    logic [awf_pkg::PIX_W-1:0]     pix2_reg;
    logic [2*awf_pkg::PIX_W-1:0]   sqr_reg;
    logic [awf_pkg::SUM_W-1:0]     sum_reg;
    logic [awf_pkg::SQ_W-1:0]      sq_sum_reg;
    logic [awf_pkg::PIX_W-1:0]     p_reg;

    // filter datapath
    logic [awf_pkg::V_W-1:0]       tmp_reg;
    logic [awf_pkg::ARITH_W-1:0]   a_reg;
    logic [awf_pkg::ARITH_W-1:0]   ad_reg;
    logic [awf_pkg::ARITH_W-1:0]   t1_reg;
    logic [awf_pkg::ARITH_W-1:0]   num_reg;
    logic [awf_pkg::ARITH_W-1:0]   den_reg;
    logic                          neg_reg;

    logic [awf_pkg::PIX_W-1:0]     mem [awf_pkg::DEPTH];

    awf_pkg::arith_rsp_t           rsp;

    // effective geometry
    logic [awf_pkg::DIM_W-1:0]     eff_w;
    logic [awf_pkg::DIM_W-1:0]     eff_h;
    logic [awf_pkg::HALF_W-1:0]    eff_hw;
    logic [awf_pkg::HALF_W-1:0]    eff_hh;
    logic [awf_pkg::PIX_W-1:0]     max_pix;
    logic [awf_pkg::CNT_W-1:0]     win_cnt;
    logic [2*awf_pkg::CNT_W-1:0]   cnt_sq;
    logic [2*awf_pkg::DIM_W-1:0]   npix_full;
    logic [awf_pkg::NPIX_W-1:0]    npix;
    logic signed [awf_pkg::OFS_W-1:0] wx_first;
    logic signed [awf_pkg::OFS_W-1:0] wy_first;

    // handshakes and addressing
    logic                          cfg_wr;
    logic                          accept;
    logic [awf_pkg::NPIX_W-1:0]    load_pos;
    logic                          mem_we;
    logic signed [awf_pkg::COORD_W+1:0] xx;
    logic signed [awf_pkg::ROW_W+1:0]   yy;
    logic [awf_pkg::COORD_W-1:0]   xc;
    logic [awf_pkg::ROW_W-1:0]     yc;
    logic [awf_pkg::ROW_W+awf_pkg::DIM_W-1:0] row_base;
    logic [awf_pkg::ADDR_W-1:0]    raddr;
    logic                          win_end;
    logic                          cur_last_x;
    logic                          cur_last;
    logic                          rd_last_x;
    logic                          rd_last;

    // arithmetic results
    logic [awf_pkg::ARITH_W+1:0]   rem2;
    logic                          round_up;
    logic [awf_pkg::ARITH_W-1:0]   rounded;
    logic [awf_pkg::PIX_W-1:0]     sat_pix;
    logic [awf_pkg::V_W-1:0]       var_now;
    logic                          a_above;
    logic [awf_pkg::SUM_W-1:0]     np;
    logic [awf_pkg::SUM_W-1:0]     np_diff;
    logic [awf_pkg::ARITH_W-1:0]   num_next;

    awf_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // geometry saturated to the supported range
    always_comb
    begin
        if (width_reg == '0)
            eff_w = awf_pkg::DIM_W'(1);
        else if (width_reg > awf_pkg::DIM_W'(awf_pkg::MAX_WIDTH))
            eff_w = awf_pkg::DIM_W'(awf_pkg::MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg == '0)
            eff_h = awf_pkg::DIM_W'(1);
        else if (height_reg > awf_pkg::DIM_W'(awf_pkg::MAX_HEIGHT))
            eff_h = awf_pkg::DIM_W'(awf_pkg::MAX_HEIGHT);
        else
            eff_h = height_reg;
        if (half_w_reg == '0)
            eff_hw = awf_pkg::HALF_W'(1);
        else if (half_w_reg > awf_pkg::HALF_W'(awf_pkg::MAX_HALF_WINDOW))
            eff_hw = awf_pkg::HALF_W'(awf_pkg::MAX_HALF_WINDOW);
        else
            eff_hw = half_w_reg;
        if (half_h_reg == '0)
            eff_hh = awf_pkg::HALF_W'(1);
        else if (half_h_reg > awf_pkg::HALF_W'(awf_pkg::MAX_HALF_WINDOW))
            eff_hh = awf_pkg::HALF_W'(awf_pkg::MAX_HALF_WINDOW);
        else
            eff_hh = half_h_reg;
    end

    assign max_pix   = depth_reg ? {awf_pkg::PIX_W{1'b1}} : awf_pkg::PIX_W'(8'hFF);
    assign win_cnt   = {eff_hw, 1'b1} * {eff_hh, 1'b1};
    assign cnt_sq    = win_cnt * win_cnt;
    assign npix_full = eff_w * eff_h;
    assign npix      = npix_full[awf_pkg::NPIX_W-1:0];
    assign wx_first  = -$signed({1'b0, eff_hw});
    assign wy_first  = -$signed({1'b0, eff_hh});

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            awf_pkg::REG_DEPTH:  prdata = awf_pkg::APB_DW'(depth_reg);
            awf_pkg::REG_HALF_W: prdata = awf_pkg::APB_DW'(half_w_reg);
            awf_pkg::REG_HALF_H: prdata = awf_pkg::APB_DW'(half_h_reg);
            awf_pkg::REG_WIDTH:  prdata = awf_pkg::APB_DW'(width_reg);
            awf_pkg::REG_HEIGHT: prdata = awf_pkg::APB_DW'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // input transaction
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign load_pos = frame_ready_reg ? '0 : load_pos_reg;
    assign mem_we   = accept && (item.mode == awf_pkg::MODE_LOAD) && (load_pos < npix);

    // window address with edge replication
    always_comb
    begin
        xx = $signed({2'b00, cur_x_reg}) + (awf_pkg::COORD_W+2)'(wx_reg);
        yy = $signed({2'b00, cur_y_reg}) + (awf_pkg::ROW_W+2)'(wy_reg);
        if (xx < 0)
            xc = '0;
        else if (xx >= $signed({1'b0, eff_w}))
            xc = awf_pkg::COORD_W'(eff_w - awf_pkg::DIM_W'(1));
        else
            xc = xx[awf_pkg::COORD_W-1:0];
        if (yy < 0)
            yc = '0;
        else if (yy >= $signed({1'b0, eff_h}))
            yc = awf_pkg::ROW_W'(eff_h - awf_pkg::DIM_W'(1));
        else
            yc = yy[awf_pkg::ROW_W-1:0];
        row_base = yc * eff_w;
        raddr    = awf_pkg::ADDR_W'(row_base) + awf_pkg::ADDR_W'(xc);
    end

    assign win_end    = (wx_reg == $signed({1'b0, eff_hw})) &&
                        (wy_reg == $signed({1'b0, eff_hh}));
    assign cur_last_x = (cur_x_reg == awf_pkg::COORD_W'(eff_w - awf_pkg::DIM_W'(1)));
    assign cur_last   = cur_last_x &&
                        (cur_y_reg == awf_pkg::ROW_W'(eff_h - awf_pkg::DIM_W'(1)));
    assign rd_last_x  = (rd_x_reg == awf_pkg::COORD_W'(eff_w - awf_pkg::DIM_W'(1)));
    assign rd_last    = (rd_pos_reg + awf_pkg::NPIX_W'(1) == npix);

    // frame store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[load_pos[awf_pkg::ADDR_W-1:0]] <= item.pixel & max_pix;
        mem_q_reg <= mem[raddr];
    end

    // rounding to nearest even of the last quotient, saturation, variance and numerator terms
    always_comb
    begin
        rem2     = {rsp.rem, 1'b0};
        round_up = (rem2 > {2'b00, den_reg}) ||
                   ((rem2 == {2'b00, den_reg}) && rsp.quo[0]);
        rounded  = rsp.quo + awf_pkg::ARITH_W'(round_up);
        sat_pix  = (rounded > awf_pkg::ARITH_W'(max_pix)) ? max_pix
                                                          : rounded[awf_pkg::PIX_W-1:0];
        var_now  = tmp_reg - rsp.quo[awf_pkg::V_W-1:0];
        a_above  = rsp.quo > awf_pkg::ARITH_W'(total_reg);
        np       = rsp.quo[awf_pkg::SUM_W-1:0];
        np_diff  = (np >= sum_reg) ? (np - sum_reg) : (sum_reg - np);
        if (!neg_reg)
            num_next = t1_reg + rsp.quo;
        else if (t1_reg >= rsp.quo)
            num_next = t1_reg - rsp.quo;
        else
            num_next = '0;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            depth_reg       <= 1'b0;
            half_w_reg      <= awf_pkg::HALF_W'(1);
            half_h_reg      <= awf_pkg::HALF_W'(1);
            width_reg       <= awf_pkg::DIM_W'(512);
            height_reg      <= awf_pkg::DIM_W'(512);
            frame_ready_reg <= 1'b0;
            pass_reg        <= 1'b0;
            load_pos_reg    <= '0;
            rd_pos_reg      <= '0;
            rd_x_reg        <= '0;
            rd_y_reg        <= '0;
            total_reg       <= '0;
            done_reg        <= 1'b0;
            req_reg.start   <= 1'b0;
            v1_reg          <= 1'b0;
            c1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            req_reg.start <= 1'b0;

            // window pipeline: read, square, accumulate
            v1_reg   <= (state_reg == S_WIN);
            c1_reg   <= (state_reg == S_WIN) && (wx_reg == '0) && (wy_reg == '0);
            v2_reg   <= v1_reg;
            pix2_reg <= mem_q_reg;
            sqr_reg  <= mem_q_reg * mem_q_reg;
            if (c1_reg)
                p_reg <= mem_q_reg;
            if (v2_reg)
            begin
                sum_reg    <= sum_reg + awf_pkg::SUM_W'(pix2_reg);
                sq_sum_reg <= sq_sum_reg + awf_pkg::SQ_W'(sqr_reg);
            end

            // register write discards the frame
            if (cfg_wr && (paddr[4:2] <= awf_pkg::REG_HEIGHT))
            begin
                unique case (paddr[4:2])
                    awf_pkg::REG_DEPTH:  depth_reg  <= pwdata[0];
                    awf_pkg::REG_HALF_W: half_w_reg <= pwdata[awf_pkg::HALF_W-1:0];
                    awf_pkg::REG_HALF_H: half_h_reg <= pwdata[awf_pkg::HALF_W-1:0];
                    awf_pkg::REG_WIDTH:  width_reg  <= pwdata[awf_pkg::DIM_W-1:0];
                    awf_pkg::REG_HEIGHT: height_reg <= pwdata[awf_pkg::DIM_W-1:0];
                    default:             depth_reg  <= depth_reg;
                endcase
                load_pos_reg    <= '0;
                rd_pos_reg      <= '0;
                rd_x_reg        <= '0;
                rd_y_reg        <= '0;
                frame_ready_reg <= 1'b0;
                total_reg       <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (item.mode == awf_pkg::MODE_LOAD))
                    begin
                        // load transaction, a new frame once the old one is complete
                        if (frame_ready_reg)
                        begin
                            frame_ready_reg <= 1'b0;
                            total_reg       <= '0;
                            rd_pos_reg      <= '0;
                            rd_x_reg        <= '0;
                            rd_y_reg        <= '0;
                        end
                        load_pos_reg <= load_pos + awf_pkg::NPIX_W'(1);
                        if (load_pos + awf_pkg::NPIX_W'(1) >= npix)
                        begin
                            total_reg  <= '0;
                            pass_reg   <= 1'b1;
                            cur_x_reg  <= '0;
                            cur_y_reg  <= '0;
                            wx_reg     <= wx_first;
                            wy_reg     <= wy_first;
                            sum_reg    <= '0;
                            sq_sum_reg <= '0;
                            state_reg  <= S_WIN;
                        end
                    end
                    else if (accept)
                    begin
                        // fetch transaction
                        if (!frame_ready_reg)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{filtered_pixel: '0, last: 1'b0,
                                            noise_variance: '0, status: 1'b1};
                        end
                        else
                        begin
                            pass_reg   <= 1'b0;
                            cur_x_reg  <= rd_x_reg;
                            cur_y_reg  <= rd_y_reg;
                            wx_reg     <= wx_first;
                            wy_reg     <= wy_first;
                            sum_reg    <= '0;
                            sq_sum_reg <= '0;
                            state_reg  <= S_WIN;
                        end
                    end
                end
                S_WIN:
                begin
                    // one window read per cycle
                    if (wx_reg == $signed({1'b0, eff_hw}))
                    begin
                        wx_reg <= wx_first;
                        wy_reg <= wy_reg + awf_pkg::OFS_W'(1);
                    end
                    else
                    begin
                        wx_reg <= wx_reg + awf_pkg::OFS_W'(1);
                    end
                    if (win_end)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                     a: awf_pkg::ARITH_W'(sq_sum_reg),
                                     b: awf_pkg::ARITH_W'(win_cnt)};
                        state_reg <= S_MUL_QC;
                    end
                end
                S_MUL_QC:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg <= rsp.quo[awf_pkg::V_W-1:0];
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                     a: awf_pkg::ARITH_W'(sum_reg),
                                     b: awf_pkg::ARITH_W'(sum_reg)};
                        state_reg <= S_MUL_SS;
                    end
                end
                S_MUL_SS:
                begin
                    if (rsp.done && pass_reg)
                    begin
                        // frame pass: accumulate n*n*var and move on
                        total_reg <= total_reg + awf_pkg::TOT_W'(var_now);
                        if (cur_last)
                        begin
                            req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                         a: awf_pkg::ARITH_W'(cnt_sq),
                                         b: awf_pkg::ARITH_W'(npix)};
                            state_reg <= S_MUL_D;
                        end
                        else
                        begin
                            if (cur_last_x)
                            begin
                                cur_x_reg <= '0;
                                cur_y_reg <= cur_y_reg + awf_pkg::ROW_W'(1);
                            end
                            else
                            begin
                                cur_x_reg <= cur_x_reg + awf_pkg::COORD_W'(1);
                            end
                            wx_reg     <= wx_first;
                            wy_reg     <= wy_first;
                            sum_reg    <= '0;
                            sq_sum_reg <= '0;
                            state_reg  <= S_WIN;
                        end
                    end
                    else if (rsp.done)
                    begin
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                     a: awf_pkg::ARITH_W'(var_now),
                                     b: awf_pkg::ARITH_W'(npix)};
                        state_reg <= S_MUL_A;
                    end
                end
                S_MUL_D:
                begin
                    if (rsp.done)
                    begin
                        den_reg <= rsp.quo;
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_DIV,
                                     a: awf_pkg::ARITH_W'({total_reg, 8'h00}),
                                     b: rsp.quo};
                        state_reg <= S_DIV_N;
                    end
                end
                S_DIV_N:
                begin
                    // noise estimate with 8 fraction bits, frame ready
                    if (rsp.done)
                    begin
                        noise_reg       <= rounded[awf_pkg::NOISE_W-1:0];
                        frame_ready_reg <= 1'b1;
                        pass_reg        <= 1'b0;
                        rd_pos_reg      <= '0;
                        rd_x_reg        <= '0;
                        rd_y_reg        <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                S_MUL_A:
                begin
                    if (rsp.done)
                    begin
                        a_reg <= rsp.quo;
                        if (!a_above)
                        begin
                            // gain zero: rounded mean
                            den_reg <= awf_pkg::ARITH_W'(win_cnt);
                            req_reg <= '{start: 1'b1, op: awf_pkg::OP_DIV,
                                         a: awf_pkg::ARITH_W'(sum_reg),
                                         b: awf_pkg::ARITH_W'(win_cnt)};
                            state_reg <= S_DIV_F;
                        end
                        else
                        begin
                            ad_reg  <= rsp.quo - awf_pkg::ARITH_W'(total_reg);
                            req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                         a: rsp.quo,
                                         b: awf_pkg::ARITH_W'(sum_reg)};
                            state_reg <= S_MUL_T1;
                        end
                    end
                end
                S_MUL_T1:
                begin
                    if (rsp.done)
                    begin
                        t1_reg  <= rsp.quo;
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                     a: awf_pkg::ARITH_W'(p_reg),
                                     b: awf_pkg::ARITH_W'(win_cnt)};
                        state_reg <= S_MUL_NP;
                    end
                end
                S_MUL_NP:
                begin
                    if (rsp.done)
                    begin
                        neg_reg <= (np < sum_reg);
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                     a: ad_reg,
                                     b: awf_pkg::ARITH_W'(np_diff)};
                        state_reg <= S_MUL_T2;
                    end
                end
                S_MUL_T2:
                begin
                    if (rsp.done)
                    begin
                        num_reg <= num_next;
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_MUL,
                                     a: a_reg,
                                     b: awf_pkg::ARITH_W'(win_cnt)};
                        state_reg <= S_MUL_DEN;
                    end
                end
                S_MUL_DEN:
                begin
                    if (rsp.done)
                    begin
                        den_reg <= rsp.quo;
                        req_reg <= '{start: 1'b1, op: awf_pkg::OP_DIV,
                                     a: num_reg,
                                     b: rsp.quo};
                        state_reg <= S_DIV_F;
                    end
                end
                S_DIV_F:
                begin
                    // filtered pixel out, readout advances and wraps
                    if (rsp.done)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{filtered_pixel: sat_pix, last: rd_last,
                                        noise_variance: noise_reg, status: 1'b0};
                        if (rd_last)
                        begin
                            rd_pos_reg <= '0;
                            rd_x_reg   <= '0;
                            rd_y_reg   <= '0;
                        end
                        else
                        begin
                            rd_pos_reg <= rd_pos_reg + awf_pkg::NPIX_W'(1);
                            if (rd_last_x)
                            begin
                                rd_x_reg <= '0;
                                rd_y_reg <= rd_y_reg + awf_pkg::ROW_W'(1);
                            end
                            else
                            begin
                                rd_x_reg <= rd_x_reg + awf_pkg::COORD_W'(1);
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `AWF_ASSERT_IMP(a_ok_needs_frame, clk, rst_n, done && !result.status, frame_ready_reg)
    `AWF_ASSERT_IMP(a_arith_free, clk, rst_n, req_reg.start, !rsp.busy)
    `AWF_ASSERT_NXT(a_div_to_result, clk, rst_n, (state_reg == S_DIV_F) && rsp.done, done && !result.status)

endmodule
